FILE: design/lru_cache_with_ttl_core_assert.svh
// Assertion macros for the LRU cache with TTL core design file.
`ifndef LRU_CACHE_WITH_TTL_CORE_ASSERT_SVH
`define LRU_CACHE_WITH_TTL_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LRUT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRUT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lrut_pkg.sv
// Shared types and codes for the LRU cache with TTL.
package lrut_pkg;

    localparam int CAP_W     = 5;
    localparam int KEY_W     = 64;
    localparam int VALUE_W   = 64;
    localparam int TIME_W    = 32;
    localparam int EXPIRY_W  = TIME_W + 1;
    localparam int COUNTER_W = 32;

    typedef enum logic [1:0] {
        FUNC_GET    = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_UNUSED = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_HIT           = 3'd0,
        ST_MISS          = 3'd1,
        ST_EXPIRED       = 3'd2,
        ST_UPDATED       = 3'd3,
        ST_INSERTED      = 3'd4,
        ST_INSERTED_EVICT = 3'd5,
        ST_REMOVED       = 3'd6,
        ST_REMOVE_ABSENT = 3'd7
    } status_t;

    typedef struct packed {
        func_t                func;
        logic [KEY_W-1:0]     lookup_key;
        logic [VALUE_W-1:0]   write_value;
        logic                 ttl_present;
        logic [TIME_W-1:0]    ttl_seconds;
        logic [TIME_W-1:0]    now_time;
    } req_t;

endpackage

FILE: design/lru_cache_with_ttl_core.sv
// Top level of the LRU cache with TTL: lookup table, recency ranks and counters.
//
// Usage:
//   Requests arrive on the input channel (in_valid / in_stall) as func,
//   lookup_key, write_value, ttl_present, ttl_seconds and now_time. Each
//   request yields exactly one result on the output channel (out_valid /
//   out_stall): status, read_value, entry_count and the four running totals.
//   A transfer happens on a rising edge with valid high and stall low.
//   out_valid rises when the request moves from the request register
//   through one pass of the compare and rank logic into the result
//   register. Throughput is one request per cycle while the receiver
//   does not stall; the whole table is matched in parallel, so nothing
//   iterates per entry. When the receiver stalls, the result register
//   holds and the table is frozen; the request register still takes one
//   more transfer if it is empty, then in_stall rises until the result
//   drains. Reset empties the table, zeroes the totals, sets capacity_limit
//   to 0 (full table depth) and clears both channel valids. capacity_limit
//   is written through the APB port at byte address 0; the user must
//   write it only while the block is idle; the block does not enforce it.
module lru_cache_with_ttl_core #(
    parameter int ENTRIES = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    // request channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             func,
    input  logic [lrut_pkg::KEY_W-1:0]             lookup_key,
    input  logic [lrut_pkg::VALUE_W-1:0]           write_value,
    input  logic                                   ttl_present,
    input  logic [lrut_pkg::TIME_W-1:0]            ttl_seconds,
    input  logic [lrut_pkg::TIME_W-1:0]            now_time,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [2:0]                             status,
    output logic [lrut_pkg::VALUE_W-1:0]           read_value,
    output logic [$clog2(ENTRIES+1)-1:0]           entry_count,
    output logic [lrut_pkg::COUNTER_W-1:0]         hit_total,
    output logic [lrut_pkg::COUNTER_W-1:0]         miss_total,
    output logic [lrut_pkg::COUNTER_W-1:0]         expired_total,
    output logic [lrut_pkg::COUNTER_W-1:0]         eviction_total
);

    `include "lru_cache_with_ttl_core_assert.svh"

    localparam int RW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > lrut_pkg::CAP_W) ? CW : lrut_pkg::CAP_W;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [lrut_pkg::CAP_W-1:0] cap_reg;
    logic                       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {{(32 - lrut_pkg::CAP_W){1'b0}}, cap_reg} : 32'd0;

    // ---------------------------------------------------------------
    // Channel control: request register feeds the result register
    // ---------------------------------------------------------------
    lrut_pkg::req_t   req_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             commit;
    logic             in_accept;

    // Move the request into the result stage when the result slot is free
    // or being drained this cycle.
    assign advance   = !out_valid_reg || !out_stall;
    assign commit    = advance && in_valid_reg;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // ---------------------------------------------------------------
    // Table state
    // ---------------------------------------------------------------
    logic [ENTRIES-1:0]                valid_reg;
    logic [lrut_pkg::KEY_W-1:0]        key_reg     [ENTRIES];
    logic [lrut_pkg::VALUE_W-1:0]      value_reg   [ENTRIES];
    logic [ENTRIES-1:0]                has_ttl_reg;
    logic [lrut_pkg::EXPIRY_W-1:0]     expiry_reg  [ENTRIES];
    logic [RW-1:0]                     rank_reg    [ENTRIES];
    logic [CW-1:0]                     count_reg;
    logic [lrut_pkg::COUNTER_W-1:0]    hit_cnt_reg;
    logic [lrut_pkg::COUNTER_W-1:0]    miss_cnt_reg;
    logic [lrut_pkg::COUNTER_W-1:0]    exp_cnt_reg;
    logic [lrut_pkg::COUNTER_W-1:0]    evict_cnt_reg;

    lrut_pkg::status_t                 status_reg;
    logic [lrut_pkg::VALUE_W-1:0]      read_value_reg;

    // ---------------------------------------------------------------
    // Lookup: parallel key match, expiry test, LRU victim
    // ---------------------------------------------------------------
    logic [ENTRIES-1:0]                hit_vec;
    logic [ENTRIES-1:0]                exp_vec;
    logic [ENTRIES-1:0]                victim_vec;
    logic [ENTRIES-1:0]                free_vec;
    logic [ENTRIES-1:0]                ins_vec;
    logic [ENTRIES-1:0]                wr_vec;
    logic [RW-1:0]                     hit_rank;
    logic [lrut_pkg::VALUE_W-1:0]      hit_value;
    logic [RW-1:0]                     lru_rank;
    logic                              found;
    logic                              expired;
    logic [CMPW-1:0]                   cap_eff;
    logic [CMPW-1:0]                   cap_ext;
    logic                              at_cap;
    logic [lrut_pkg::EXPIRY_W-1:0]     new_expiry;

    // Live ranks are always 0..count-1, so the LRU entry holds count-1.
    assign lru_rank = RW'(count_reg - CW'(1));

    always_comb
    begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i]    = valid_reg[i] && (key_reg[i] == req_reg.lookup_key);
            exp_vec[i]    = hit_vec[i] && has_ttl_reg[i]
                            && ({1'b0, req_reg.now_time} > expiry_reg[i]);
            victim_vec[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
            hit_rank      = hit_rank  | (hit_vec[i] ? rank_reg[i]  : '0);
            hit_value     = hit_value | (hit_vec[i] ? value_reg[i] : '0);
        end
    end

    assign found   = |hit_vec;
    assign expired = |exp_vec;

    // Capacity of 0, or anything above the table depth, means the full table.
    assign cap_ext = CMPW'(cap_reg);
    assign cap_eff = ((cap_reg == '0) || (cap_ext > CMPW'(ENTRIES))) ? CMPW'(ENTRIES) : cap_ext;
    assign at_cap  = CMPW'(count_reg) >= cap_eff;

    assign new_expiry = req_reg.ttl_present
                        ? ({1'b0, req_reg.now_time} + {1'b0, req_reg.ttl_seconds})
                        : '0;

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    logic                              do_touch;
    logic                              do_drop;
    logic                              do_insert;
    logic                              do_evict;
    logic                              do_write;
    logic                              inc_hit;
    logic                              inc_miss;
    logic                              inc_exp;
    lrut_pkg::status_t                 status_next;
    logic [lrut_pkg::VALUE_W-1:0]      read_value_next;

    always_comb
    begin
        do_touch        = 1'b0;
        do_drop         = 1'b0;
        do_insert       = 1'b0;
        do_evict        = 1'b0;
        do_write        = 1'b0;
        inc_hit         = 1'b0;
        inc_miss        = 1'b0;
        inc_exp         = 1'b0;
        status_next     = lrut_pkg::ST_MISS;
        read_value_next = '0;
        case (req_reg.func)
            lrut_pkg::FUNC_GET:
            begin
                if (!found)
                begin
                    inc_miss    = 1'b1;
                    status_next = lrut_pkg::ST_MISS;
                end
                else if (expired)
                begin
                    do_drop     = 1'b1;
                    inc_miss    = 1'b1;
                    inc_exp     = 1'b1;
                    status_next = lrut_pkg::ST_EXPIRED;
                end
                else
                begin
                    do_touch        = 1'b1;
                    inc_hit         = 1'b1;
                    read_value_next = hit_value;
                    status_next     = lrut_pkg::ST_HIT;
                end
            end
            lrut_pkg::FUNC_SET:
            begin
                do_write = 1'b1;
                if (found)
                begin
                    do_touch    = 1'b1;
                    status_next = lrut_pkg::ST_UPDATED;
                end
                else
                begin
                    do_insert   = 1'b1;
                    do_evict    = at_cap;
                    status_next = at_cap ? lrut_pkg::ST_INSERTED_EVICT
                                         : lrut_pkg::ST_INSERTED;
                end
            end
            lrut_pkg::FUNC_REMOVE:
            begin
                do_drop     = found;
                status_next = found ? lrut_pkg::ST_REMOVED : lrut_pkg::ST_REMOVE_ABSENT;
            end
            default:
            begin
                status_next = lrut_pkg::ST_MISS;
            end
        endcase
    end

    // Insert goes to the lowest free slot, counting a slot freed by eviction.
    assign free_vec = ~valid_reg | (do_evict ? victim_vec : '0);
    assign ins_vec  = free_vec & (~free_vec + ENTRIES'(1));
    assign wr_vec   = found ? hit_vec : ins_vec;

    // ---------------------------------------------------------------
    // Valid and rank update
    // ---------------------------------------------------------------
    logic [ENTRIES-1:0]    valid_next;
    logic [RW-1:0]         rank_next [ENTRIES];
    logic [CW-1:0]         count_next;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
            if (do_touch)
            begin
                if (hit_vec[i])
                    rank_next[i] = '0;
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    rank_next[i] = rank_reg[i] + RW'(1);
            end
            else if (do_drop)
            begin
                if (hit_vec[i])
                    valid_next[i] = 1'b0;
                else if (valid_reg[i] && (rank_reg[i] > hit_rank))
                    rank_next[i] = rank_reg[i] - RW'(1);
            end
            else if (do_insert)
            begin
                if (ins_vec[i])
                begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end
                else if (do_evict && victim_vec[i])
                    valid_next[i] = 1'b0;
                else if (valid_reg[i])
                    rank_next[i] = rank_reg[i] + RW'(1);
            end
        end

        count_next = count_reg;
        if (do_drop)
            count_next = count_reg - CW'(1);
        else if (do_insert && !do_evict)
            count_next = count_reg + CW'(1);
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            exp_cnt_reg   <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_write)
                cap_reg <= pwdata[lrut_pkg::CAP_W-1:0];

            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= in_valid_reg;

            if (commit)
            begin
                valid_reg <= valid_next;
                count_reg <= count_next;
                if (inc_hit)
                    hit_cnt_reg <= hit_cnt_reg + 32'd1;
                if (inc_miss)
                    miss_cnt_reg <= miss_cnt_reg + 32'd1;
                if (inc_exp)
                    exp_cnt_reg <= exp_cnt_reg + 32'd1;
                if (do_evict)
                    evict_cnt_reg <= evict_cnt_reg + 32'd1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers: request, result and table contents
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg.func        <= lrut_pkg::func_t'(func);
            req_reg.lookup_key  <= lookup_key;
            req_reg.write_value <= write_value;
            req_reg.ttl_present <= ttl_present;
            req_reg.ttl_seconds <= ttl_seconds;
            req_reg.now_time    <= now_time;
        end

        if (commit)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
                if (do_write && wr_vec[i])
                begin
                    value_reg[i]   <= req_reg.write_value;
                    has_ttl_reg[i] <= req_reg.ttl_present;
                    expiry_reg[i]  <= new_expiry;
                end
                if (do_insert && ins_vec[i])
                    key_reg[i] <= req_reg.lookup_key;
            end
        end
    end

    // ---------------------------------------------------------------
    // Outputs: totals and count hold while the result waits
    // ---------------------------------------------------------------
    assign status         = status_reg;
    assign read_value     = read_value_reg;
    assign entry_count    = count_reg;
    assign hit_total      = hit_cnt_reg;
    assign miss_total     = miss_cnt_reg;
    assign expired_total  = exp_cnt_reg;
    assign eviction_total = evict_cnt_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `LRUT_ASSERT_NOW(a_key_unique, in_valid_reg, $onehot0(hit_vec), "duplicate live key")
    `LRUT_ASSERT_NOW(a_count_match, 1'b1, $countones(valid_reg) == int'(count_reg), "count out of step with valid bits")
    `LRUT_ASSERT_NOW(a_one_lru, count_reg != '0, $onehot(victim_vec), "LRU rank not unique")
    `LRUT_ASSERT_NEXT(a_evict_count, commit && do_evict, evict_cnt_reg == $past(evict_cnt_reg) + 32'd1, "eviction not counted")

endmodule

FILE: test/lru_cache_with_ttl_core_test.sv
// Self-checking testbench for the LRU cache with TTL core: directed table, random phases, APB setup.
module lru_cache_with_ttl_core_test;

    import lrut_pkg::*;

    localparam int ENTRIES         = 16;
    localparam int COUNT_W         = $clog2(ENTRIES + 1);
    localparam int NUM_DRILL       = 22;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int KEY_POOL        = 20;
    localparam int DRAIN_GAP       = 4;     // margin past the request and result registers
    localparam int QUIET_LIMIT     = 4000;  // cycles without any transfer
    localparam int PRINT_LIMIT     = 100;

    localparam logic [2:0] CAP_ADDR = 3'd0;  // capacity_limit register

    localparam logic [63:0] ALL1 = '1;
    localparam logic [63:0] K5   = {16{4'h5}};
    localparam logic [63:0] KA   = {16{4'hA}};
    localparam logic [63:0] KX   = 64'h0123_4567_89AB_CDEF;
    localparam logic [31:0] TMAX = '1;

    // Per phase: capacity written before it, then the idle and stall modes (phase mod 4).
    localparam int CAP_PLAN [NUM_PHASES] = '{16, 2, 31, 1, 0, 5, 17, 3};
    localparam int IDLE_PLAN  [4] = '{0, 81, 0, 8};
    localparam int STALL_PLAN [4] = '{0, 0, 81, 8};

    // One result of the block, field by field.
    typedef struct packed {
        status_t                 status;
        logic [VALUE_W-1:0]      read_value;
        logic [COUNT_W-1:0]      entry_count;
        logic [COUNTER_W-1:0]    hits;
        logic [COUNTER_W-1:0]    misses;
        logic [COUNTER_W-1:0]    expired;
        logic [COUNTER_W-1:0]    evictions;
    } outcome_t;

    // Directed row: request, and a hand-written result where it is obvious.
    typedef struct packed {
        req_t     req;
        logic     typed;
        outcome_t want;
    } drill_row_t;

    // One live entry of the predicted cache.
    typedef struct {
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
        logic                has_ttl;
        logic [EXPIRY_W-1:0] expiry;
    } cache_line_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic     in_valid = 1'b0;
    logic     in_stall;
    req_t     req_word = '0;
    logic     typed_flag = 1'b0;
    outcome_t typed_want = '0;

    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [2:0]               status;
    logic [VALUE_W-1:0]       read_value;
    logic [COUNT_W-1:0]       entry_count;
    logic [COUNTER_W-1:0]     hit_total;
    logic [COUNTER_W-1:0]     miss_total;
    logic [COUNTER_W-1:0]     expired_total;
    logic [COUNTER_W-1:0]     eviction_total;

    // Predicted cache: front of the list is the most recently used entry.
    cache_line_t          recency_list [$];
    logic [CAP_W-1:0]     capacity_cfg = '0;
    logic [COUNTER_W-1:0] hits_seen = '0;
    logic [COUNTER_W-1:0] misses_seen = '0;
    logic [COUNTER_W-1:0] expiries_seen = '0;
    logic [COUNTER_W-1:0] evictions_seen = '0;

    outcome_t         pending_results [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL];
    logic [31:0]      wall_clock = '0;
    int               idle_pct = 0;
    int               stall_pct = 0;
    int               err_count = 0;
    int               quiet_cycles = 0;

    // Directed part: empty-table cases, field extremes, the expiry boundary,
    // set and remove on expired keys, and the unused request code.
    drill_row_t drill_table [NUM_DRILL] = '{
        '{'{FUNC_GET, 64'd0, 64'd0, 1'b0, 32'd0, 32'd0}, 1'b1,
          '{ST_MISS, 64'd0, 5'd0, 32'd0, 32'd1, 32'd0, 32'd0}},
        '{'{FUNC_REMOVE, ALL1, ALL1, 1'b1, TMAX, TMAX}, 1'b1,
          '{ST_REMOVE_ABSENT, 64'd0, 5'd0, 32'd0, 32'd1, 32'd0, 32'd0}},
        '{'{FUNC_UNUSED, 64'd0, ALL1, 1'b1, TMAX, 32'd0}, 1'b1,
          '{ST_MISS, 64'd0, 5'd0, 32'd0, 32'd1, 32'd0, 32'd0}},
        '{'{FUNC_SET, 64'd0, ALL1, 1'b0, TMAX, 32'd0}, 1'b1,
          '{ST_INSERTED, 64'd0, 5'd1, 32'd0, 32'd1, 32'd0, 32'd0}},
        '{'{FUNC_GET, 64'd0, 64'd0, 1'b0, 32'd0, TMAX}, 1'b1,
          '{ST_HIT, ALL1, 5'd1, 32'd1, 32'd1, 32'd0, 32'd0}},
        '{'{FUNC_SET, ALL1, 64'd0, 1'b1, 32'd0, TMAX}, 1'b1,
          '{ST_INSERTED, 64'd0, 5'd2, 32'd1, 32'd1, 32'd0, 32'd0}},
        // now equal to the expiry is still live
        '{'{FUNC_GET, ALL1, 64'd0, 1'b0, 32'd0, TMAX}, 1'b1,
          '{ST_HIT, 64'd0, 5'd2, 32'd2, 32'd1, 32'd0, 32'd0}},
        // largest TTL on largest time: expiry needs the 33rd bit
        '{'{FUNC_SET, K5, KA, 1'b1, TMAX, TMAX}, 1'b1,
          '{ST_INSERTED, 64'd0, 5'd3, 32'd2, 32'd1, 32'd0, 32'd0}},
        '{'{FUNC_GET, K5, 64'd0, 1'b0, 32'd0, TMAX}, 1'b1,
          '{ST_HIT, KA, 5'd3, 32'd3, 32'd1, 32'd0, 32'd0}},
        '{'{FUNC_SET, KA, K5, 1'b1, 32'd5, 32'd100}, 1'b1,
          '{ST_INSERTED, 64'd0, 5'd4, 32'd3, 32'd1, 32'd0, 32'd0}},
        '{'{FUNC_GET, KA, 64'd0, 1'b0, 32'd0, 32'd105}, 1'b1,
          '{ST_HIT, K5, 5'd4, 32'd4, 32'd1, 32'd0, 32'd0}},
        // one second past the expiry: dropped, counted as miss and expiry
        '{'{FUNC_GET, KA, 64'd0, 1'b0, 32'd0, 32'd106}, 1'b1,
          '{ST_EXPIRED, 64'd0, 5'd3, 32'd4, 32'd2, 32'd1, 32'd0}},
        '{'{FUNC_GET, KA, 64'd0, 1'b0, 32'd0, 32'd106}, 1'b1,
          '{ST_MISS, 64'd0, 5'd3, 32'd4, 32'd3, 32'd1, 32'd0}},
        // set on an expired key updates it in place
        '{'{FUNC_SET, KX, 64'd1, 1'b1, 32'd0, 32'd10}, 1'b0, '0},
        '{'{FUNC_SET, KX, 64'd2, 1'b0, 32'd0, 32'd50}, 1'b0, '0},
        '{'{FUNC_GET, KX, 64'd0, 1'b0, 32'd0, 32'd50}, 1'b0, '0},
        // remove on an expired key removes it, no counter moves
        '{'{FUNC_SET, 64'd7, 64'd7, 1'b1, 32'd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_REMOVE, 64'd7, 64'd0, 1'b0, 32'd0, 32'd1}, 1'b0, '0},
        '{'{FUNC_REMOVE, 64'd0, 64'd0, 1'b0, 32'd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_GET, 64'd0, 64'd0, 1'b0, 32'd0, 32'd0}, 1'b0, '0},
        // unused code on a live key leaves it alone
        '{'{FUNC_UNUSED, ALL1, 64'd9, 1'b0, 32'd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_GET, ALL1, 64'd0, 1'b0, 32'd0, 32'd0}, 1'b0, '0}
    };

    lru_cache_with_ttl_core #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (req_word.func),
        .lookup_key     (req_word.lookup_key),
        .write_value    (req_word.write_value),
        .ttl_present    (req_word.ttl_present),
        .ttl_seconds    (req_word.ttl_seconds),
        .now_time       (req_word.now_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_value     (read_value),
        .entry_count    (entry_count),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .expired_total  (expired_total),
        .eviction_total (eviction_total)
    );

    always #10 clk = ~clk;

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic log_error(input string what);
        if (err_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s", $time, what);
        err_count++;
    endtask

    task automatic compare_field(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            log_error($sformatf("%s got %h want %h", field, got, want));
    endtask

    // Apply one request to the predicted cache and return its result.
    // Only the recency order matters, so keep the entries as an ordered list.
    function automatic outcome_t cache_access(input req_t r);
        outcome_t    o;
        cache_line_t line;
        int          at;
        int          room;
        at = -1;
        foreach (recency_list[i])
            if (recency_list[i].key == r.lookup_key)
                at = i;
        o = '0;
        o.status = ST_MISS;
        line.key = r.lookup_key;
        line.value = r.write_value;
        line.has_ttl = r.ttl_present;
        // expiry is 33 bits: time plus lifetime never wraps
        line.expiry = r.ttl_present ? {1'b0, r.now_time} + {1'b0, r.ttl_seconds} : '0;
        case (r.func)
            FUNC_GET:
            begin
                if (at < 0)
                    misses_seen++;
                else if (recency_list[at].has_ttl &&
                         {1'b0, r.now_time} > recency_list[at].expiry)
                begin
                    recency_list.delete(at);
                    misses_seen++;
                    expiries_seen++;
                    o.status = ST_EXPIRED;
                end
                else
                begin
                    line = recency_list[at];
                    recency_list.delete(at);
                    recency_list.push_front(line);
                    hits_seen++;
                    o.read_value = line.value;
                    o.status = ST_HIT;
                end
            end
            FUNC_SET:
            begin
                if (at >= 0)
                begin
                    recency_list.delete(at);
                    o.status = ST_UPDATED;
                end
                else
                begin
                    room = (capacity_cfg == 0 || capacity_cfg > ENTRIES) ? ENTRIES
                                                                          : capacity_cfg;
                    o.status = ST_INSERTED;
                    // a single eviction, even when the limit was lowered below the count
                    if (recency_list.size() >= room)
                    begin
                        recency_list.delete(recency_list.size() - 1);
                        evictions_seen++;
                        o.status = ST_INSERTED_EVICT;
                    end
                end
                recency_list.push_front(line);
            end
            FUNC_REMOVE:
            begin
                if (at >= 0)
                begin
                    recency_list.delete(at);
                    o.status = ST_REMOVED;
                end
                else
                    o.status = ST_REMOVE_ABSENT;
            end
            default:
                ;
        endcase
        o.entry_count = COUNT_W'(recency_list.size());
        o.hits = hits_seen;
        o.misses = misses_seen;
        o.expired = expiries_seen;
        o.evictions = evictions_seen;
        return o;
    endfunction

    // Random request: mostly keys from a small pool so hits, updates,
    // expiries and evictions happen; time creeps forward with rare jumps.
    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 40)
            r.func = FUNC_GET;
        else if (pick < 80)
            r.func = FUNC_SET;
        else if (pick < 95)
            r.func = FUNC_REMOVE;
        else
            r.func = FUNC_UNUSED;
        if ($urandom_range(99) < 88)
            r.lookup_key = key_pool[$urandom_range(KEY_POOL - 1)];
        else
            r.lookup_key = {$urandom, $urandom};
        r.write_value = {$urandom, $urandom};
        r.ttl_present = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 80)
            r.ttl_seconds = $urandom_range(30);
        else if (pick < 90)
            r.ttl_seconds = $urandom;
        else
            r.ttl_seconds = '0;
        if ($urandom_range(99) < 3)
            wall_clock = $urandom;
        else
            wall_clock = wall_clock + $urandom_range(2);
        r.now_time = wall_clock;
        return r;
    endfunction

    // Offer one request, with random idle cycles first; return once the
    // transfer has happened. Valid stays high for a following request.
    task automatic send_request(input req_t r, input logic typed, input outcome_t want);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_word <= r;
        typed_flag <= typed;
        typed_want <= want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid, wait until every expected result has arrived, then let
    // the pipeline settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // APB write of capacity_limit, then read it back.
    task automatic write_capacity(input logic [CAP_W-1:0] limit);
        logic [31:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= {{(32 - CAP_W){1'b0}}, limit};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        capacity_cfg = limit;
        // read setup: keep psel, drop the write
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        compare_field("capacity_limit readback", 64'(readback[CAP_W-1:0]), 64'(limit));
    endtask

    // Receiver: stall at random at the rate of the current phase.
    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // Monitor: check each result transfer against the oldest expectation,
    // then predict the result of each request transfer.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        logic     moved;
        if (rst_n)
        begin
            moved = psel;
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                got = {status_t'(status), read_value, entry_count, hit_total,
                       miss_total, expired_total, eviction_total};
                if (pending_results.size() == 0)
                    log_error($sformatf("result with nothing pending, status %0d", status));
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("status", 64'(got.status), 64'(want.status));
                    compare_field("read_value", got.read_value, want.read_value);
                    compare_field("entry_count", 64'(got.entry_count),
                                  64'(want.entry_count));
                    compare_field("hit_total", 64'(got.hits), 64'(want.hits));
                    compare_field("miss_total", 64'(got.misses), 64'(want.misses));
                    compare_field("expired_total", 64'(got.expired), 64'(want.expired));
                    compare_field("eviction_total", 64'(got.evictions),
                                  64'(want.evictions));
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                // advance the predictor even when the row carries its own result
                want = cache_access(req_word);
                pending_results.insert(pending_results.size(),
                                       typed_flag ? typed_want : want);
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing has moved for too long.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("lru_cache_with_ttl_core_test: done, errors");
        $finish;
    end

    initial
    begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < KEY_POOL; k++)
            key_pool[k] = {$urandom, $urandom};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part runs at the reset capacity (full table).
        foreach (drill_table[n])
            send_request(drill_table[n].req, drill_table[n].typed, drill_table[n].want);

        // Random phases: new capacity while idle, then a burst of requests
        // under one of the idle and stall modes.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            write_capacity(CAP_W'(CAP_PLAN[p]));
            idle_pct = IDLE_PLAN[p % 4];
            stall_pct = STALL_PLAN[p % 4];
            repeat (ITEMS_PER_PHASE)
                send_request(random_request(), 1'b0, '0);
        end

        drain_results();
        if (err_count == 0)
            $display("lru_cache_with_ttl_core_test: done, clean");
        else
            $display("lru_cache_with_ttl_core_test: done, errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/lrut_pkg.sv
design/lru_cache_with_ttl_core.sv
test/lru_cache_with_ttl_core_test.sv
